// ===== hdl/hskt_pkg.sv =====
// ----------------------------------------------------------------------------
// hskt_pkg: shared types and constants
// Hash constants, default sizes and the status words passed between units.
// ----------------------------------------------------------------------------
package hskt_pkg;

  localparam int unsigned TABLE_EXP_DEF     = 10;
  localparam int unsigned MAX_KEY_BYTES_DEF = 32;

  localparam int unsigned HASH_W     = 64;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SLOT_IDX_W = 10;

  localparam logic [HASH_W-1:0] HASH_SEED = 64'h100;
  localparam logic [HASH_W-1:0] HASH_MULT = 64'd1111111111111111111;
  localparam logic [31:0]       MULT_LO   = HASH_MULT[31:0];
  localparam logic [31:0]       MULT_HI   = HASH_MULT[63:32];

  // job queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/hskt_front.sv =====
// ----------------------------------------------------------------------------
// hskt_front: byte intake and running hash
// Takes key bytes, keeps the 64-bit hash with one shared 32x32 multiplier
// through states MUL1, MUL2 and MUL3, buffers bytes and pushes a lookup job on the last byte.
// ----------------------------------------------------------------------------
module hskt_front #(
  parameter int unsigned MAX_KEY_BYTES = hskt_pkg::MAX_KEY_BYTES_DEF,
  localparam int unsigned LEN_W  = $clog2(MAX_KEY_BYTES + 1),
  localparam int unsigned BA_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [hskt_pkg::BYTE_W-1:0]  key_byte_i,
  input  logic                         last_byte_i,
  input  hskt_pkg::q_stat_t            q_stat_i,
  input  logic                         clearing_i,
  output logic                         full_o,
  output logic                         pw_en_o,
  output logic [BA_W-1:0]              pw_addr_o,
  output logic [hskt_pkg::BYTE_W-1:0]  pw_data_o,
  output logic                         job_push_o,
  output logic [hskt_pkg::HASH_W-1:0]  job_hash_o,
  output logic [LEN_W-1:0]             job_len_o,
  output logic                         job_ovf_o
);
  import hskt_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL1 = 4'b0010,
    F_MUL2 = 4'b0100,
    F_MUL3 = 4'b1000
  } front_state_e;

  front_state_e      state_q, state_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic              last_q;
  logic [HASH_W-1:0] x_q;
  logic [HASH_W-1:0] lo_q;
  logic [31:0]       cross_q;
  logic [31:0]       mul_a, mul_b;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] hash_new;
  logic              accept;
  logic              room;

  assign full_o  = (state_q != F_IDLE) || q_stat_i.full || clearing_i;
  assign accept  = push_i && !full_o;
  assign room    = (len_q != LEN_W'(MAX_KEY_BYTES));

  assign pw_en_o   = accept && room;
  assign pw_addr_o = len_q[BA_W-1:0];
  assign pw_data_o = key_byte_i;

  // low 64 bits of x * MULT from three partial products
  assign mul_a    = (state_q == F_MUL3) ? x_q[63:32] : x_q[31:0];
  assign mul_b    = (state_q == F_MUL2) ? MULT_HI : MULT_LO;
  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign hash_new = {lo_q[63:32] + cross_q + prod[31:0], lo_q[31:0]};

  assign job_push_o = (state_q == F_MUL3) && last_q;
  assign job_hash_o = hash_new;
  assign job_len_o  = len_q;
  assign job_ovf_o  = ovf_q;

  always_comb begin
    state_d = state_q;
    hash_d  = hash_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_MUL1;
          if (room) len_d = len_q + LEN_W'(1);
          else      ovf_d = 1'b1;
        end
      end
      F_MUL1: state_d = F_MUL2;
      F_MUL2: state_d = F_MUL3;
      F_MUL3: begin
        state_d = F_IDLE;
        if (last_q) begin
          hash_d = HASH_SEED;
          len_d  = '0;
          ovf_d  = 1'b0;
        end else begin
          hash_d = hash_new;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      hash_q  <= HASH_SEED;
      len_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= hash_q ^ HASH_W'(key_byte_i);
      last_q <= last_byte_i;
    end
    if (state_q == F_MUL1) lo_q    <= prod;
    if (state_q == F_MUL2) cross_q <= prod[31:0];
  end

endmodule

// ===== hdl/hskt_queue.sv =====
// ----------------------------------------------------------------------------
// hskt_queue: two-entry job queue with key byte banks
// Each entry owns one bank of buffered key bytes; the front fills the bank
// at the write pointer, the back reads the bank at the read pointer.
// ----------------------------------------------------------------------------
module hskt_queue #(
  parameter int unsigned MAX_KEY_BYTES = hskt_pkg::MAX_KEY_BYTES_DEF,
  localparam int unsigned LEN_W  = $clog2(MAX_KEY_BYTES + 1),
  localparam int unsigned BA_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pw_en_i,
  input  logic [BA_W-1:0]              pw_addr_i,
  input  logic [hskt_pkg::BYTE_W-1:0]  pw_data_i,
  input  logic                         job_push_i,
  input  logic [hskt_pkg::HASH_W-1:0]  job_hash_i,
  input  logic [LEN_W-1:0]             job_len_i,
  input  logic                         job_ovf_i,
  input  logic                         job_pop_i,
  input  logic [BA_W-1:0]              pr_addr_i,
  output logic [hskt_pkg::BYTE_W-1:0]  pr_data_o,
  output hskt_pkg::q_stat_t            q_stat_o,
  output logic [hskt_pkg::HASH_W-1:0]  head_hash_o,
  output logic [LEN_W-1:0]             head_len_o,
  output logic                         head_ovf_o
);
  import hskt_pkg::*;

  logic [BYTE_W-1:0] bank_mem [2**(BA_W+1)];
  logic [HASH_W-1:0] hash_q [2];
  logic [LEN_W-1:0]  len_q  [2];
  logic              ovf_q  [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  assign q_stat_o.full  = (cnt_q == 2'd2);
  assign q_stat_o.empty = (cnt_q == 2'd0);
  assign head_hash_o = hash_q[rd_ptr_q];
  assign head_len_o  = len_q[rd_ptr_q];
  assign head_ovf_o  = ovf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (pw_en_i) bank_mem[{wr_ptr_q, pw_addr_i}] <= pw_data_i;
    pr_data_o <= bank_mem[{rd_ptr_q, pr_addr_i}];
    if (job_push_i) begin
      hash_q[wr_ptr_q] <= job_hash_i;
      len_q[wr_ptr_q]  <= job_len_i;
      ovf_q[wr_ptr_q]  <= job_ovf_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (job_push_i) wr_ptr_q <= ~wr_ptr_q;
      if (job_pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(job_push_i) - 2'(job_pop_i);
    end
  end

endmodule

// ===== hdl/hskt_back.sv =====
// ----------------------------------------------------------------------------
// hskt_back: table probe engine
// Double-hash probing of the slot table, key compare and key store, one
// result word held in an output register.
// ----------------------------------------------------------------------------
module hskt_back #(
  parameter int unsigned TABLE_EXP     = hskt_pkg::TABLE_EXP_DEF,
  parameter int unsigned MAX_KEY_BYTES = hskt_pkg::MAX_KEY_BYTES_DEF,
  localparam int unsigned LEN_W  = $clog2(MAX_KEY_BYTES + 1),
  localparam int unsigned BA_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hskt_pkg::q_stat_t                q_stat_i,
  input  logic [hskt_pkg::HASH_W-1:0]      job_hash_i,
  input  logic [LEN_W-1:0]                 job_len_i,
  input  logic                             job_ovf_i,
  output logic                             job_pop_o,
  output logic [BA_W-1:0]                  pr_addr_o,
  input  logic [hskt_pkg::BYTE_W-1:0]      pr_data_i,
  output logic                             clearing_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [hskt_pkg::SLOT_IDX_W-1:0]  slot_index_o,
  output logic                             inserted_o,
  output logic                             table_full_o,
  output logic                             key_too_long_o,
  output logic [hskt_pkg::HASH_W-1:0]      key_hash_o
);
  import hskt_pkg::*;

  typedef enum logic [7:0] {
    B_CLEAR   = 8'b00000001,
    B_IDLE    = 8'b00000010,
    B_READ    = 8'b00000100,
    B_CHECK   = 8'b00001000,
    B_COPY_RD = 8'b00010000,
    B_COPY_WR = 8'b00100000,
    B_CMP_RD  = 8'b01000000,
    B_CMP_CHK = 8'b10000000
  } back_state_e;

  localparam logic [TABLE_EXP-1:0] LAST_SLOT = '1;

  back_state_e          state_q, state_d;
  logic [TABLE_EXP-1:0] idx_q, idx_d;
  logic [TABLE_EXP-1:0] step_q, step_d;
  logic [TABLE_EXP-1:0] n_q, n_d;
  logic [TABLE_EXP-1:0] clr_q, clr_d;
  logic [BA_W-1:0]      k_q, k_d;
  logic                 k_last;

  // slot metadata: {valid, length}, cleared by a sweep after reset
  logic [LEN_W:0]       meta_mem [2**TABLE_EXP];
  logic [LEN_W:0]       meta_rd_q;
  logic                 meta_we;
  logic [TABLE_EXP-1:0] meta_wa;
  logic [LEN_W:0]       meta_wd;

  logic [BYTE_W-1:0]    key_mem [2**(TABLE_EXP+BA_W)];
  logic [BYTE_W-1:0]    key_rd_q;
  logic                 key_we;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [TABLE_EXP-1:0] res_slot;
  logic                 res_ins, res_full, res_long;
  logic [TABLE_EXP-1:0] out_slot_q;
  logic                 out_ins_q, out_full_q, out_long_q;
  logic [HASH_W-1:0]    out_hash_q;
  logic [SLOT_IDX_W+TABLE_EXP-1:0] slot_ext;

  assign clearing_o = (state_q == B_CLEAR);
  assign pr_addr_o  = k_q;
  assign k_last     = ((LEN_W'(k_q) + LEN_W'(1)) == job_len_i);
  assign job_pop_o  = out_load;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    step_d   = step_q;
    n_d      = n_q;
    clr_d    = clr_q;
    k_d      = k_q;
    meta_we  = 1'b0;
    meta_wa  = idx_q;
    meta_wd  = {1'b1, job_len_i};
    key_we   = 1'b0;
    out_load = 1'b0;
    res_slot = idx_q;
    res_ins  = 1'b0;
    res_full = 1'b0;
    res_long = 1'b0;
    case (state_q)
      B_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
        meta_wd = '0;
        clr_d   = clr_q + TABLE_EXP'(1);
        if (clr_q == LAST_SLOT) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!q_stat_i.empty && !out_valid_q) begin
          if (job_ovf_i) begin
            out_load = 1'b1;
            res_slot = '0;
            res_long = 1'b1;
          end else begin
            step_d  = job_hash_i[HASH_W-1 -: TABLE_EXP] | TABLE_EXP'(1);
            idx_d   = job_hash_i[TABLE_EXP-1:0] + step_d;
            n_d     = '0;
            state_d = B_READ;
          end
        end
      end
      B_READ: state_d = B_CHECK;
      B_CHECK: begin
        k_d = '0;
        if (!meta_rd_q[LEN_W]) begin
          meta_we = 1'b1;
          state_d = B_COPY_RD;
        end else if (meta_rd_q[LEN_W-1:0] == job_len_i) begin
          state_d = B_CMP_RD;
        end else if (n_q == LAST_SLOT) begin
          out_load = 1'b1;
          res_slot = '0;
          res_full = 1'b1;
          state_d  = B_IDLE;
        end else begin
          n_d     = n_q + TABLE_EXP'(1);
          idx_d   = idx_q + step_q;
          state_d = B_READ;
        end
      end
      B_COPY_RD: state_d = B_COPY_WR;
      B_COPY_WR: begin
        key_we = 1'b1;
        if (k_last) begin
          out_load = 1'b1;
          res_ins  = 1'b1;
          state_d  = B_IDLE;
        end else begin
          k_d     = k_q + BA_W'(1);
          state_d = B_COPY_RD;
        end
      end
      B_CMP_RD: state_d = B_CMP_CHK;
      B_CMP_CHK: begin
        if (key_rd_q != pr_data_i) begin
          if (n_q == LAST_SLOT) begin
            out_load = 1'b1;
            res_slot = '0;
            res_full = 1'b1;
            state_d  = B_IDLE;
          end else begin
            n_d     = n_q + TABLE_EXP'(1);
            idx_d   = idx_q + step_q;
            state_d = B_READ;
          end
        end else if (k_last) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end else begin
          k_d     = k_q + BA_W'(1);
          state_d = B_CMP_RD;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) out_valid_d = 1'b0;
    if (out_load)             out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    step_q <= step_d;
    n_q    <= n_d;
    k_q    <= k_d;
    if (out_load) begin
      out_slot_q <= res_slot;
      out_ins_q  <= res_ins;
      out_full_q <= res_full;
      out_long_q <= res_long;
      out_hash_q <= job_hash_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_q <= meta_mem[idx_q];
    if (key_we) key_mem[{idx_q, k_q}] <= pr_data_i;
    key_rd_q <= key_mem[{idx_q, k_q}];
  end

  assign slot_ext       = {{SLOT_IDX_W{1'b0}}, out_slot_q};
  assign empty_o        = !out_valid_q;
  assign slot_index_o   = slot_ext[SLOT_IDX_W-1:0];
  assign inserted_o     = out_ins_q;
  assign table_full_o   = out_full_q;
  assign key_too_long_o = out_long_q;
  assign key_hash_o     = out_hash_q;

  a_no_job_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> !job_pop_o)
    else $error("job retired during clearing sweep");

  a_retire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> out_valid_q)
    else $error("retired job left no result");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_ins_q && out_full_q) && !(out_long_q && (out_ins_q || out_full_q)))
    else $error("conflicting result flags");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q)
    else $error("result register overwritten");

endmodule

// ===== hdl/hashed_string_key_table_top.sv =====
// ----------------------------------------------------------------------------
// hashed_string_key_table_top: string key table with double hashing
// Keys arrive a byte per word; on the last byte the key is looked up and
// stored if new and a slot is free, returning its slot index and hash.
//
//   channel  direction  words                              handshake
//   -------  ---------  ---------------------------------  -----------
//   input    in         key_byte_i, last_byte_i            push_i/full_o
//   result   out        slot_index_o, inserted_o,          pop_i/empty_o
//                       table_full_o, key_too_long_o,
//                       key_hash_o
//
// Intake: the front takes no new byte until the hash multiply of the last
//   one is done; the multiply runs through one shared 32x32 multiplier.
// Lookup: each probed slot and each key byte compared or copied is read,
//   then checked or written, through the slot and key byte memories.
// Reset: a sweep clears the slot valid marks of all 2**TABLE_EXP slots;
//   full_o stays high until it is done.
// Stalls: a two-entry job queue decouples byte intake from probing, and a
//   held result word does not stop intake until the queue fills.
// ----------------------------------------------------------------------------
module hashed_string_key_table_top #(
  parameter int unsigned TABLE_EXP     = hskt_pkg::TABLE_EXP_DEF,
  parameter int unsigned MAX_KEY_BYTES = hskt_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [hskt_pkg::BYTE_W-1:0]      key_byte_i,
  input  logic                             last_byte_i,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [hskt_pkg::SLOT_IDX_W-1:0]  slot_index_o,
  output logic                             inserted_o,
  output logic                             table_full_o,
  output logic                             key_too_long_o,
  output logic [hskt_pkg::HASH_W-1:0]      key_hash_o
);
  import hskt_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned BA_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  // front to queue
  logic              pw_en;
  logic [BA_W-1:0]   pw_addr;
  logic [BYTE_W-1:0] pw_data;
  logic              job_push;
  logic [HASH_W-1:0] job_hash;
  logic [LEN_W-1:0]  job_len;
  logic              job_ovf;

  // between queue and back; clearing goes from back to front
  q_stat_t           q_stat;
  logic [HASH_W-1:0] head_hash;
  logic [LEN_W-1:0]  head_len;
  logic              head_ovf;
  logic              job_pop;
  logic [BA_W-1:0]   pr_addr;
  logic [BYTE_W-1:0] pr_data;
  logic              clearing;

  hskt_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .key_byte_i (key_byte_i),
    .last_byte_i(last_byte_i),
    .q_stat_i   (q_stat),
    .clearing_i (clearing),
    .full_o     (full_o),
    .pw_en_o    (pw_en),
    .pw_addr_o  (pw_addr),
    .pw_data_o  (pw_data),
    .job_push_o (job_push),
    .job_hash_o (job_hash),
    .job_len_o  (job_len),
    .job_ovf_o  (job_ovf)
  );

  hskt_queue #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pw_en_i    (pw_en),
    .pw_addr_i  (pw_addr),
    .pw_data_i  (pw_data),
    .job_push_i (job_push),
    .job_hash_i (job_hash),
    .job_len_i  (job_len),
    .job_ovf_i  (job_ovf),
    .job_pop_i  (job_pop),
    .pr_addr_i  (pr_addr),
    .pr_data_o  (pr_data),
    .q_stat_o   (q_stat),
    .head_hash_o(head_hash),
    .head_len_o (head_len),
    .head_ovf_o (head_ovf)
  );

  hskt_back #(
    .TABLE_EXP    (TABLE_EXP),
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .job_hash_i    (head_hash),
    .job_len_i     (head_len),
    .job_ovf_i     (head_ovf),
    .job_pop_o     (job_pop),
    .pr_addr_o     (pr_addr),
    .pr_data_i     (pr_data),
    .clearing_o    (clearing),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .slot_index_o  (slot_index_o),
    .inserted_o    (inserted_o),
    .table_full_o  (table_full_o),
    .key_too_long_o(key_too_long_o),
    .key_hash_o    (key_hash_o)
  );

endmodule
